@@ src/rrf_pkg.sv @@
`default_nettype none

package rrf_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_BYTES_DEF = 32;
    localparam int LEN_W          = 7;

    typedef enum logic [1:0] {
        KIND_WR_ACK   = 2'd0,
        KIND_RD_DATA  = 2'd1,
        KIND_RD_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_USED  = 2'd1,
        FILL_FULL  = 2'd2
    } fill_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_DROPPED = 2'd1,
        ERR_TRUNC   = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_LEN,
        ST_RD_BYTES
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        out_byte;
        logic              end_of_run;
        logic [LEN_W-1:0]  record_length;
        fill_t             fill_status;
        err_t              error;
    } res_t;

endpackage

`default_nettype wire

@@ src/record_ring_fifo.sv @@
// Ring buffer of SLOT_COUNT record slots of SLOT_BYTES bytes each, with a
// stored length per slot. Each input transfer is either one byte of a record
// being written (last marks the final byte, which commits the slot) or a
// request to read the oldest record. A write byte gives one acknowledge; bytes
// past SLOT_BYTES are discarded and flagged, and a record that starts while
// the ring is full is dropped whole and flagged. One slot always stays unused,
// so full means SLOT_COUNT-1 records. A read of a non-empty ring holds off
// input until its last byte is issued (a stored length of zero counts as one
// byte): the accept cycle looks up the length memory, the RD_LEN state latches
// it, then the record memory read port streams one byte per cycle while the
// output queue has room; result back-pressure stalls it. A read of an empty
// ring is refused with an empty-kind result. Results pass through a two-entry
// output queue, so input keeps flowing while a result waits downstream. The
// memories need no initialization after reset.
`default_nettype none

module record_ring_fifo #(
    parameter int SLOT_COUNT = rrf_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = rrf_pkg::SLOT_BYTES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_stall,
    input  wire logic                     op,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     last,
    output      logic                     out_valid,
    input  wire logic                     out_stall,
    output      logic [1:0]               kind,
    output      logic [7:0]               out_byte,
    output      logic                     end_of_run,
    output      logic [rrf_pkg::LEN_W-1:0] record_length,
    output      logic [1:0]               fill_status,
    output      logic [1:0]               error
);

    import rrf_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(SLOT_BYTES));
    endfunction

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]   read_slot_reg, read_slot_next;
    fill_t               status_reg, status_next;
    logic [CNT_W-1:0]    wcount_reg, wcount_next;
    logic                dropping_reg, dropping_next;
    logic [ADDR_W-1:0]   rd_base_reg, rd_base_next;
    fill_t               rd_status_reg, rd_status_next;
    logic [CNT_W-1:0]    rd_len_reg, rd_len_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_ram_reg, s1_ram_next;
    res_t                s1_res_reg, s1_res_next;
    res_t                fifo_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg;

    logic                rec_we, rec_re;
    logic [ADDR_W-1:0]   rec_waddr, rec_raddr;
    logic [7:0]          rec_rdata;
    logic                len_we, len_re;
    logic [SLOT_W-1:0]   len_waddr, len_raddr;
    logic [CNT_W-1:0]    len_wdata, len_rdata, len_clip;

    logic                in_accept, pop, push, credit;
    logic [2:0]          occupancy;
    logic                rd_last, start_drop, wr_full, rd_empty;
    logic [SLOT_W-1:0]   ws_adv, rs_adv;
    logic [CNT_W-1:0]    wc_inc;
    res_t                push_res, head;

    rrf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (data_byte),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    rrf_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    // queue space, counting the result stage and this cycle's pop
    assign pop       = out_valid && !out_stall;
    assign push      = s1_valid_reg;
    assign occupancy = {1'b0, count_reg} + {2'b00, s1_valid_reg};
    assign credit    = occupancy < (pop ? 3'd3 : 3'd2);
    assign in_stall  = (state_reg != ST_IDLE) || !credit;
    assign in_accept = in_valid && !in_stall;

    assign ws_adv     = next_slot(write_slot_reg);
    assign rs_adv     = next_slot(read_slot_reg);
    assign wr_full    = next_slot(ws_adv) == read_slot_reg;
    assign rd_empty   = rs_adv == write_slot_reg;
    assign start_drop = (wcount_reg == '0) && !dropping_reg && (status_reg == FILL_FULL);
    assign wc_inc     = wcount_reg + 1'b1;
    assign len_clip   = (len_rdata > CNT_W'(SLOT_BYTES)) ? CNT_W'(SLOT_BYTES) : len_rdata;
    assign rd_last    = (rd_len_reg == '0) || (rd_idx_reg + 1'b1 == rd_len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && op && (status_reg != FILL_EMPTY))
                begin
                    state_next = ST_RD_LEN;
                end
            end
            ST_RD_LEN:
            begin
                state_next = ST_RD_BYTES;
            end
            ST_RD_BYTES:
            begin
                if (credit && rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        status_next     = status_reg;
        wcount_next     = wcount_reg;
        dropping_next   = dropping_reg;
        rd_base_next    = rd_base_reg;
        rd_status_next  = rd_status_reg;
        rd_len_next     = rd_len_reg;
        rd_idx_next     = rd_idx_reg;
        s1_valid_next   = 1'b0;
        s1_ram_next     = 1'b0;
        s1_res_next     = s1_res_reg;
        rec_we          = 1'b0;
        rec_waddr       = slot_base(write_slot_reg) + ADDR_W'(wcount_reg);
        rec_re          = 1'b0;
        rec_raddr       = rd_base_reg + ADDR_W'(rd_idx_reg);
        len_we          = 1'b0;
        len_waddr       = write_slot_reg;
        len_wdata       = wcount_reg;
        len_re          = 1'b0;
        len_raddr       = read_slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !op)
                begin
                    s1_valid_next          = 1'b1;
                    s1_res_next.kind       = KIND_WR_ACK;
                    s1_res_next.out_byte   = '0;
                    s1_res_next.end_of_run = 1'b1;
                    if (dropping_reg || start_drop)
                    begin
                        s1_res_next.error         = ERR_DROPPED;
                        s1_res_next.record_length = '0;
                        s1_res_next.fill_status   = status_reg;
                        dropping_next             = !last;
                    end
                    else
                    begin
                        if (wcount_reg < CNT_W'(SLOT_BYTES))
                        begin
                            rec_we                = 1'b1;
                            len_wdata             = wc_inc;
                            wcount_next           = wc_inc;
                            s1_res_next.error     = ERR_NONE;
                        end
                        else
                        begin
                            s1_res_next.error     = ERR_TRUNC;
                        end
                        s1_res_next.record_length = LEN_W'(len_wdata);
                        s1_res_next.fill_status   = status_reg;
                        if (last)
                        begin
                            len_we                  = 1'b1;
                            write_slot_next         = ws_adv;
                            status_next             = wr_full ? FILL_FULL : FILL_USED;
                            wcount_next             = '0;
                            s1_res_next.fill_status = wr_full ? FILL_FULL : FILL_USED;
                        end
                    end
                end
                else if (in_accept && (status_reg == FILL_EMPTY))
                begin
                    s1_valid_next             = 1'b1;
                    s1_res_next.kind          = KIND_RD_EMPTY;
                    s1_res_next.out_byte      = '0;
                    s1_res_next.end_of_run    = 1'b1;
                    s1_res_next.record_length = '0;
                    s1_res_next.fill_status   = FILL_EMPTY;
                    s1_res_next.error         = ERR_NONE;
                end
                else if (in_accept)
                begin
                    len_re         = 1'b1;
                    read_slot_next = rs_adv;
                    status_next    = rd_empty ? FILL_EMPTY : FILL_USED;
                    rd_status_next = rd_empty ? FILL_EMPTY : FILL_USED;
                    rd_base_next   = slot_base(read_slot_reg);
                end
            end
            ST_RD_LEN:
            begin
                rd_len_next = len_clip;
                rd_idx_next = '0;
            end
            ST_RD_BYTES:
            begin
                if (credit)
                begin
                    s1_valid_next             = 1'b1;
                    s1_res_next.kind          = KIND_RD_DATA;
                    s1_res_next.out_byte      = '0;
                    s1_res_next.end_of_run    = rd_last;
                    s1_res_next.record_length = LEN_W'(rd_len_reg);
                    s1_res_next.fill_status   = rd_status_reg;
                    s1_res_next.error         = ERR_NONE;
                    rd_idx_next               = rd_idx_reg + 1'b1;
                    if (rd_len_reg != '0)
                    begin
                        rec_re      = 1'b1;
                        s1_ram_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push_res = s1_res_reg;
        if (s1_ram_reg)
        begin
            push_res.out_byte = rec_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            status_reg     <= FILL_EMPTY;
            wcount_reg     <= '0;
            dropping_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_ram_reg     <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            status_reg     <= status_next;
            wcount_reg     <= wcount_next;
            dropping_reg   <= dropping_next;
            s1_valid_reg   <= s1_valid_next;
            s1_ram_reg     <= s1_ram_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_base_reg   <= rd_base_next;
        rd_status_reg <= rd_status_next;
        rd_len_reg    <= rd_len_next;
        rd_idx_reg    <= rd_idx_next;
        s1_res_reg    <= s1_res_next;
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_res;
        end
    end

    assign head          = fifo_reg[rd_ptr_reg];
    assign out_valid     = count_reg != '0;
    assign kind          = head.kind;
    assign out_byte      = head.out_byte;
    assign end_of_run    = head.end_of_run;
    assign record_length = head.record_length;
    assign fill_status   = head.fill_status;
    assign error         = head.error;

    // result stage always finds a free queue entry
    a_queue_space: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (count_reg != 2'd2))
        else $error("result pushed into full output queue");

    a_full_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == FILL_FULL) |-> (next_slot(write_slot_reg) == read_slot_reg))
        else $error("full status without one free slot");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == FILL_EMPTY) |-> (read_slot_reg == write_slot_reg))
        else $error("empty status with pointers apart");

    a_read_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && in_valid && !in_stall && op && (status_reg != FILL_EMPTY)
        |=> in_stall ##1 in_stall)
        else $error("input taken during record read");

endmodule

`default_nettype wire

@@ src/rrf_ram.sv @@
`default_nettype none

module rrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire
